>>> rtl/core/adhr_pkg.sv
// adhr_pkg: shared types, codes and constants for the ADHR envelope generator.
// No dependencies; imported by the interfaces and every module in rtl/core.
package adhr_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 15;
  localparam int CFG_BITS        = 16;
  localparam int CFG_IDX_BITS    = 3;
  localparam int KIND_BITS       = 2;

  // Item kinds; code 3 is ignored.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_TICK     = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_HOLD    = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ATTACK_RATE  = 3'd0,
    REG_DECAY_RATE   = 3'd1,
    REG_HOLD_RATE    = 3'd2,
    REG_RELEASE_RATE = 3'd3,
    REG_HOLD_LEVEL   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] attack_rate;
    logic [CFG_BITS-1:0] decay_rate;
    logic [CFG_BITS-1:0] hold_rate;
    logic [CFG_BITS-1:0] release_rate;
    logic [CFG_BITS-1:0] hold_level;
  } cfg_t;

  // Amplitude register width: FRAC_BITS+3, but never narrower than a
  // zero-extended register value plus sign, since hold_level loads directly.
  function automatic int amp_width(input int frac_bits);
    int w;
    w = frac_bits + 3;
    return (w > CFG_BITS + 1) ? w : CFG_BITS + 1;
  endfunction

endpackage

>>> rtl/core/adhr_in_if.sv
// adhr_in_if: input channel (valid/ready) carrying kind and sample_in.
// Depends on adhr_pkg.
interface adhr_in_if
  import adhr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [KIND_BITS-1:0]          kind;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, kind, sample_in, input ready);
  modport sink   (input valid, kind, sample_in, output ready);
endinterface

>>> rtl/core/adhr_out_if.sv
// adhr_out_if: result channel (valid/ready) carrying sample_out.
// Depends on adhr_pkg.
interface adhr_out_if
  import adhr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

>>> rtl/core/adhr_cfg_if.sv
// adhr_cfg_if: configuration write channel (valid/ready, index, data).
// Depends on adhr_pkg.
interface adhr_cfg_if
  import adhr_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CFG_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/adhr_cfg_regs.sv
// adhr_cfg_regs: configuration register file, one write beat per cycle.
// Depends on adhr_pkg and adhr_cfg_if.
module adhr_cfg_regs
  import adhr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  adhr_cfg_if.sink        cfg_ch,
  output cfg_t            cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ATTACK_RATE:  cfg_nxt.attack_rate  = cfg_ch.data;
        REG_DECAY_RATE:   cfg_nxt.decay_rate   = cfg_ch.data;
        REG_HOLD_RATE:    cfg_nxt.hold_rate    = cfg_ch.data;
        REG_RELEASE_RATE: cfg_nxt.release_rate = cfg_ch.data;
        REG_HOLD_LEVEL:   cfg_nxt.hold_level   = cfg_ch.data;
        default:          cfg_nxt = cfg_r;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/core/adhr_env_core.sv
// adhr_env_core: phase/amplitude state and its combinational update per beat.
// Depends on adhr_pkg.
module adhr_env_core
  import adhr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int AW       = amp_width(FRAC_BITS)
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [KIND_BITS-1:0] kind,
  input  cfg_t                 cfg,
  output logic signed [AW-1:0] amp_o,
  output logic                 active_o
);

  localparam int    AMP_BITS = FRAC_BITS + 3;
  localparam int    SW       = AW + 1;
  localparam longint AMP_MAX_L = (longint'(1) << (AMP_BITS - 1)) - 1;
  localparam longint AMP_MIN_L = -(longint'(1) << (AMP_BITS - 1));
  localparam logic signed [SW-1:0] SUM_MAX = SW'(AMP_MAX_L);
  localparam logic signed [SW-1:0] SUM_MIN = SW'(AMP_MIN_L);
  localparam logic signed [AW-1:0] FULL_SCALE = AW'(longint'(1) << FRAC_BITS);

  phase_t               phase_r, phase_nxt;
  logic signed [AW-1:0] amp_r, amp_nxt;
  logic signed [SW-1:0] rate;
  logic signed [SW-1:0] sum;
  logic signed [AW-1:0] sum_sat;
  logic signed [AW-1:0] hold_lvl;

  assign hold_lvl = AW'($signed({1'b0, cfg.hold_level}));

  // Next state: events only move phase; a tick steps amplitude then phase.
  always_comb begin
    rate = '0;
    case (phase_r)
      PH_ATTACK:  rate =  SW'($signed({1'b0, cfg.attack_rate}));
      PH_DECAY:   rate = -SW'($signed({1'b0, cfg.decay_rate}));
      PH_HOLD:    rate = -SW'($signed({1'b0, cfg.hold_rate}));
      PH_RELEASE: rate = -SW'($signed({1'b0, cfg.release_rate}));
      default:    rate = '0;
    endcase

    sum = SW'(amp_r) + rate;
    if (sum > SUM_MAX) begin
      sum_sat = AW'(SUM_MAX);
    end else if (sum < SUM_MIN) begin
      sum_sat = AW'(SUM_MIN);
    end else begin
      sum_sat = AW'(sum);
    end

    phase_nxt = phase_r;
    amp_nxt   = amp_r;
    case (kind)
      KIND_TICK: begin
        amp_nxt = sum_sat;
        if (amp_nxt <= 0) begin
          phase_nxt = PH_IDLE;
        end
        if (phase_nxt == PH_ATTACK && amp_nxt >= FULL_SCALE) begin
          amp_nxt   = FULL_SCALE;
          phase_nxt = PH_DECAY;
        end
        // decay may be entered and left in the same tick
        if (phase_nxt == PH_DECAY && amp_nxt <= hold_lvl) begin
          amp_nxt   = hold_lvl;
          phase_nxt = PH_HOLD;
        end
      end
      KIND_NOTE_ON:  phase_nxt = PH_ATTACK;
      KIND_NOTE_OFF: phase_nxt = PH_RELEASE;
      default:       phase_nxt = phase_r;
    endcase
  end

  // Outputs: gain used for this tick's sample.
  always_comb begin
    amp_o    = amp_nxt;
    active_o = (phase_nxt != PH_IDLE) && (amp_nxt > 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      amp_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      amp_r   <= amp_nxt;
    end
  end

  a_idle_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> amp_r <= 0)
    else $error("idle phase with positive amplitude");

  a_decay_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DECAY |-> (amp_r > 0) && (amp_r <= FULL_SCALE))
    else $error("decay amplitude outside (0, full scale]");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_RELEASE)
    else $error("unused phase code reached");

endmodule

>>> rtl/core/adhr_scale.sv
// adhr_scale: sample times envelope gain, floor shift and saturation; zero when inactive.
// Depends on adhr_pkg.
module adhr_scale
  import adhr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int AW         = amp_width(FRAC_BITS)
)(
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [AW-1:0]          amp,
  input  logic                          active,
  output logic signed [SAMPLE_BITS-1:0] scaled
);

  localparam int PW = SAMPLE_BITS + AW;
  localparam logic signed [PW-1:0] S_MAX = PW'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PW-1:0] S_MIN = PW'(-(longint'(1) << (SAMPLE_BITS - 1)));

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] quot;

  // arithmetic shift of the signed product is floor division by 2^FRAC_BITS
  always_comb begin
    prod = PW'(sample) * PW'(amp);
    quot = prod >>> FRAC_BITS;
    if (!active) begin
      scaled = '0;
    end else if (quot > S_MAX) begin
      scaled = SAMPLE_BITS'(S_MAX);
    end else if (quot < S_MIN) begin
      scaled = SAMPLE_BITS'(S_MIN);
    end else begin
      scaled = quot[SAMPLE_BITS-1:0];
    end
  end

endmodule

>>> rtl/core/adhr_envelope_generator.sv
// adhr_envelope_generator: top level of the ADHR envelope unit.
// Depends on adhr_pkg, the adhr_*_if interfaces, adhr_cfg_regs,
// adhr_env_core and adhr_scale.
//
// Five-phase envelope (idle, attack, decay, hold, release) that scales a
// stream of signed samples. Each beat on in_ch is a note-on, a note-off or a
// sample tick; only ticks produce a beat on out_ch, and kind 3 is dropped.
// Throughput is one beat per clock while out_ch.ready stays high: the
// amplitude add, the phase compares and the sample multiply all sit
// combinationally between the input register and the result register, so
// the amplitude feedback loop closes through the amplitude register alone.
// A beat is captured in the input register when accepted and moves on to
// the result register once that is empty or being read. The
// input register accepts a new beat while a finished result is still waiting
// on out_ch; only when both are held does in_ch.ready drop. Configuration
// (attack/decay/hold/release rates and hold level, Q FRAC_BITS) is written
// through cfg_ch, always ready, and must only change while the unit is idle.
module adhr_envelope_generator
  import adhr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  adhr_in_if.sink     in_ch,
  adhr_out_if.source  out_ch,
  adhr_cfg_if.sink    cfg_ch
);

  localparam int AW = amp_width(FRAC_BITS);

  // input register
  logic                          in_v_r, in_v_nxt;
  logic [KIND_BITS-1:0]          kind_r;
  logic signed [SAMPLE_BITS-1:0] smp_r;

  // result register
  logic                          out_v_r, out_v_nxt;
  logic signed [SAMPLE_BITS-1:0] out_smp_r;

  logic                          proc;    // input beat consumed this cycle
  logic                          is_tick;
  cfg_t                          cfg;
  logic signed [AW-1:0]          amp;
  logic                          active;
  logic signed [SAMPLE_BITS-1:0] scaled;

  assign is_tick      = (kind_r == KIND_TICK);
  assign proc         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || proc;
  assign out_ch.valid = out_v_r;
  assign out_ch.sample_out = out_smp_r;

  adhr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  adhr_env_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (proc),
    .kind     (kind_r),
    .cfg      (cfg),
    .amp_o    (amp),
    .active_o (active)
  );

  adhr_scale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_scale (
    .sample (smp_r),
    .amp    (amp),
    .active (active),
    .scaled (scaled)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_ch.ready) begin
      in_v_nxt = in_ch.valid;
    end
    out_v_nxt = out_v_r;
    if (proc) begin
      out_v_nxt = is_tick;      // events leave the result slot empty
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r <= in_ch.kind;
      smp_r  <= in_ch.sample_in;
    end
    if (proc && is_tick) begin
      out_smp_r <= scaled;
    end
  end

  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && is_tick |=> out_v_r)
    else $error("tick consumed without a result");

  a_event_silent: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !is_tick |=> !out_v_r)
    else $error("event or unused kind produced a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |-> !proc)
    else $error("pending result overwritten");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for adhr_envelope_generator (envelope phases, scaling).
// Depends on adhr_pkg, adhr_in_if, adhr_out_if, adhr_cfg_if and the RTL top.
module tb
  import adhr_pkg::*;
;

  localparam int SB    = SAMPLE_BITS_DEF;
  localparam int FB    = FRAC_BITS_DEF;
  localparam int AMP_W = FB + 3;

  localparam longint FULL_SCALE = longint'(1) << FB;
  localparam longint AMP_MAX    = (longint'(1) << (AMP_W - 1)) - 1;
  localparam longint AMP_MIN    = -(longint'(1) << (AMP_W - 1));
  localparam longint OUT_MAX    = (longint'(1) << (SB - 1)) - 1;
  localparam longint OUT_MIN    = -(longint'(1) << (SB - 1));

  // Worst case allows for gaps and stalls on ~1300 beats,
  // taken several times over.
  localparam int CYCLE_LIMIT  = 600000;
  // Events leave no result, so pad a little past the last expected beat.
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 125;
  localparam int RAND_PHASES  = 8;

  // kind code that the block drops
  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  adhr_in_if  #(.SAMPLE_BITS(SB)) in_bus ();
  adhr_out_if #(.SAMPLE_BITS(SB)) out_bus ();
  adhr_cfg_if                     cfg_bus ();

  adhr_envelope_generator #(
    .SAMPLE_BITS(SB),
    .FRAC_BITS  (FB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  // ---------------------------------------------------------------------------
  // Envelope predictor: own copy of registers, amplitude and phase.
  // ---------------------------------------------------------------------------
  cfg_t                    env_regs;
  logic signed [AMP_W-1:0] env_amp;
  phase_t                  env_phase;

  // Expected sample_out beats, oldest first.
  logic signed [SB-1:0] pending_samples [$];

  int  err_count;
  int  cycle_count;
  bit  calm;          // when set, neither side idles

  always #10 clk = ~clk;

  // Apply one accepted input beat; returns 1 when it yields a result beat.
  function automatic bit envelope_step(input logic [KIND_BITS-1:0] kind,
                                       input logic signed [SB-1:0] smp,
                                       output logic signed [SB-1:0] res);
    longint sum;
    longint amp;
    longint prod;
    longint q;
    res = '0;
    if (kind == KIND_NOTE_ON) begin
      env_phase = PH_ATTACK;
      return 1'b0;
    end
    if (kind == KIND_NOTE_OFF) begin
      env_phase = PH_RELEASE;
      return 1'b0;
    end
    if (kind != KIND_TICK) return 1'b0;

    // rate of the current phase; idle (and any unused code) adds nothing
    sum = longint'(env_amp);
    case (env_phase)
      PH_ATTACK:  sum = sum + longint'(env_regs.attack_rate);
      PH_DECAY:   sum = sum - longint'(env_regs.decay_rate);
      PH_HOLD:    sum = sum - longint'(env_regs.hold_rate);
      PH_RELEASE: sum = sum - longint'(env_regs.release_rate);
      default:    sum = sum;
    endcase
    // amplitude saturates at its own signed width
    if (sum > AMP_MAX) sum = AMP_MAX;
    if (sum < AMP_MIN) sum = AMP_MIN;
    amp = sum;

    if (amp <= 0) env_phase = PH_IDLE;
    if (env_phase == PH_IDLE) begin
      env_amp = amp[AMP_W-1:0];
      return 1'b1;
    end
    if (env_phase == PH_ATTACK && amp >= FULL_SCALE) begin
      amp = FULL_SCALE;
      env_phase = PH_DECAY;
    end
    // decay may start and end in the same tick
    if (env_phase == PH_DECAY && amp <= longint'(env_regs.hold_level)) begin
      amp = longint'(env_regs.hold_level);
      env_phase = PH_HOLD;
    end
    env_amp = amp[AMP_W-1:0];
    if (amp <= 0) return 1'b1;

    // floor(sample * amp / 2^FB), saturated to the sample range
    prod = longint'(smp) * amp;
    q = prod >>> FB;
    if (q > OUT_MAX) q = OUT_MAX;
    if (q < OUT_MIN) q = OUT_MIN;
    res = q[SB-1:0];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none, some short, a few long.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return {1'b0, {(SB-1){1'b1}}};   // most positive
    if (r < 16) return {1'b1, {(SB-1){1'b0}}};   // most negative
    if (r < 20) return '0;
    if (r < 24) return {SB{1'b1}};               // -1
    return SB'($urandom());
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_rate();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 16) return CFG_BITS'(FULL_SCALE);
    if (r < 22) return {CFG_BITS{1'b1}};
    if (r < 32) return CFG_BITS'($urandom());
    return CFG_BITS'($urandom_range(200, 9000));
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 16) return CFG_BITS'(FULL_SCALE);
    if (r < 22) return {CFG_BITS{1'b1}};
    if (r < 32) return CFG_BITS'($urandom());
    return CFG_BITS'($urandom_range(1000, 30000));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: optional idle gap, then one beat held until accepted.
  // valid is only lowered at the start of a gap, so it never toggles twice
  // in one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [KIND_BITS-1:0] kind,
                           input logic signed [SB-1:0] smp);
    int gap;
    logic signed [SB-1:0] res;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= kind;
    in_bus.sample_in <= smp;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    if (envelope_step(kind, smp, res)) pending_samples.push_back(res);
  endtask

  task automatic send_tick(input logic signed [SB-1:0] smp);
    send_item(KIND_TICK, smp);
  endtask

  // Stop sending and wait until every expected beat has come out, plus
  // DRAIN_CYCLES of padding for trailing events.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back; only called with the block drained.
  task automatic write_all_regs(input cfg_t c);
    cfg_idx_t order [5] = '{REG_ATTACK_RATE, REG_DECAY_RATE, REG_HOLD_RATE,
                            REG_RELEASE_RATE, REG_HOLD_LEVEL};
    logic [CFG_BITS-1:0] v;
    foreach (order[i]) begin
      case (order[i])
        REG_ATTACK_RATE:  v = c.attack_rate;
        REG_DECAY_RATE:   v = c.decay_rate;
        REG_HOLD_RATE:    v = c.hold_rate;
        REG_RELEASE_RATE: v = c.release_rate;
        default:          v = c.hold_level;
      endcase
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= order[i];
      cfg_bus.data  <= v;
      @(posedge clk);
      while (cfg_bus.ready !== 1'b1) @(posedge clk);
    end
    cfg_bus.valid <= 1'b0;
    env_regs = c;
  endtask

  task automatic set_envelope(input logic [CFG_BITS-1:0] atk, input logic [CFG_BITS-1:0] dcy,
                              input logic [CFG_BITS-1:0] hld, input logic [CFG_BITS-1:0] rel,
                              input logic [CFG_BITS-1:0] lvl);
    cfg_t c;
    c.attack_rate  = atk;
    c.decay_rate   = dcy;
    c.hold_rate    = hld;
    c.release_rate = rel;
    c.hold_level   = lvl;
    write_all_regs(c);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers are all zero: every tick must come out as zero, kind 3
  // is dropped, and a note-on with zero attack falls straight back to idle.
  task automatic test_reset_state();
    send_tick({1'b0, {(SB-1){1'b1}}});
    send_tick({1'b1, {(SB-1){1'b0}}});
    send_item(KIND_UNUSED, 16'sd1234);
    send_item(KIND_NOTE_ON, '0);
    send_tick(16'sd12345);
    send_item(KIND_NOTE_OFF, '0);
    send_tick(-16'sd7);
    wait_drained();
  endtask

  // One clean note through attack, decay, hold and release, with a pause
  // mid-note until the result queue is empty.
  task automatic test_full_note();
    set_envelope(16'd16384, 16'd8192, 16'd2048, 16'd8192, 16'd16384);
    send_item(KIND_NOTE_ON, '0);
    send_tick({1'b0, {(SB-1){1'b1}}});
    send_tick({1'b1, {(SB-1){1'b0}}});     // reaches full scale, enters decay
    wait_drained();
    send_tick(16'sd1);
    send_item(KIND_UNUSED, -16'sd1);
    send_tick(-16'sd1);
    send_tick(16'sd0);                      // in hold, steps down by the hold rate
    send_tick({1'b0, {(SB-1){1'b1}}});
    send_item(KIND_NOTE_OFF, '0);
    repeat (3) send_tick(-16'sd20000);
    wait_drained();
  endtask

  // Registers at and beyond full scale: attack, decay and hold in one tick,
  // output saturation, amplitude driven to its negative limit by repeated
  // note-offs in idle, then repeated note-ons at the top attack rate.
  task automatic test_register_extremes();
    set_envelope(CFG_BITS'(FULL_SCALE), CFG_BITS'(FULL_SCALE), '0, {CFG_BITS{1'b1}},
                 {CFG_BITS{1'b1}});
    send_item(KIND_NOTE_ON, '0);
    send_tick({1'b0, {(SB-1){1'b1}}});      // hold above full scale: saturates high
    send_tick({1'b1, {(SB-1){1'b0}}});      // saturates low
    repeat (4) begin
      send_item(KIND_NOTE_OFF, '0);
      send_tick(16'sd100);
    end
    wait_drained();
    set_envelope({CFG_BITS{1'b1}}, '0, '0, '0, '0);
    repeat (4) begin
      send_item(KIND_NOTE_ON, '0);
      send_tick(-16'sd30000);
    end
    wait_drained();
  endtask

  // Fixed register sets first, then random ones; mostly well-formed notes
  // with random content, some noise beats and broken sequences.
  task automatic test_random_notes();
    int sent;
    int n;
    int r;
    cfg_t c;
    for (int p = 0; p < RAND_PHASES; p++) begin
      calm = (p % 3 == 2);
      case (p)
        0: begin
          c = '1;                            // every register at its top
        end
        1: begin
          c.attack_rate  = 16'd1;
          c.decay_rate   = '0;
          c.hold_rate    = 16'd1;
          c.release_rate = CFG_BITS'(FULL_SCALE);
          c.hold_level   = CFG_BITS'(FULL_SCALE);
        end
        default: begin
          c.attack_rate  = pick_rate();
          c.decay_rate   = pick_rate();
          c.hold_rate    = pick_rate();
          c.release_rate = pick_rate();
          c.hold_level   = pick_level();
        end
      endcase
      write_all_regs(c);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // well-formed note
          send_item(KIND_NOTE_ON, pick_sample());
          n = $urandom_range(1, 40);
          repeat (n) send_tick(pick_sample());
          sent += n + 1;
          if ($urandom_range(0, 9) != 0) begin
            send_item(KIND_NOTE_OFF, pick_sample());
            n = $urandom_range(1, 40);
            repeat (n) send_tick(pick_sample());
            sent += n + 1;
          end
        end else if (r < 86) begin
          send_item(KIND_UNUSED, pick_sample());
          sent += 1;
        end else begin
          // noise: any kind
          n = $urandom_range(1, 8);
          repeat (n) send_item(KIND_BITS'($urandom_range(0, 3)), pick_sample());
          sent += n;
        end
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
      wait_drained();
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure on out_bus.ready.
  // ---------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_bus.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      out_bus.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    logic signed [SB-1:0] want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, sample_out=%0d",
                                  out_bus.sample_out));
      end else begin
        want = pending_samples.pop_front();
        if (out_bus.sample_out !== want)
          report_mismatch($sformatf("sample_out=%0d, expected %0d",
                                    out_bus.sample_out, want));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    calm              = 1'b0;
    err_count         = 0;
    cycle_count       = 0;
    in_bus.valid      = 1'b0;
    in_bus.kind       = KIND_TICK;
    in_bus.sample_in  = '0;
    out_bus.ready     = 1'b1;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_ATTACK_RATE;
    cfg_bus.data      = '0;
    env_regs          = '0;
    env_amp           = '0;
    env_phase         = PH_IDLE;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_full_note();
    test_register_extremes();
    test_random_notes();

    wait_drained();
    if (pending_samples.size() != 0)
      report_mismatch($sformatf("%0d expected beats never came", pending_samples.size()));

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/adhr_pkg.sv
rtl/core/adhr_in_if.sv
rtl/core/adhr_out_if.sv
rtl/core/adhr_cfg_if.sv
rtl/core/adhr_cfg_regs.sv
rtl/core/adhr_env_core.sv
rtl/core/adhr_scale.sv
rtl/core/adhr_envelope_generator.sv
verif/tb.sv
